FILE: src/tspmtc_pkg.sv
`default_nettype none

package tspmtc_pkg;

    // Matrix geometry
    localparam int MAX_NODES   = 128;
    localparam int NODE_BITS   = $clog2(MAX_NODES);
    localparam int ROW_BITS    = NODE_BITS + 1;
    localparam int ADDR_BITS   = 2 * NODE_BITS;
    localparam int WEIGHT_BITS = 24;
    localparam int SUM_BITS    = 31;
    localparam logic [SUM_BITS-1:0] SUM_MAX = {SUM_BITS{1'b1}};

    // Configuration port
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 8;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_NODE_COUNT    = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_MATRIX_FORMAT = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_ASYMMETRIC    = 2'd2;
    localparam logic [CFG_DATA_BITS-1:0]  NODE_COUNT_RESET  = 8'd128;

    typedef enum logic [1:0] {
        CMD_BEGIN_LOAD,
        CMD_WEIGHT,
        CMD_TOUR,
        CMD_READ
    } cmd_t;

    typedef enum logic [1:0] {
        FMT_FULL_MATRIX,
        FMT_LOWER_DIAG_ROW,
        FMT_LOWER_ROW,
        FMT_NONE
    } fmt_t;

    typedef enum logic [1:0] {
        STAT_OK,
        STAT_LOAD_FULL,
        STAT_BAD_VERTEX
    } stat_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC,
        ST_MIRROR,
        ST_STEP_ADD,
        ST_CLOSE,
        ST_CLOSE_ADD,
        ST_READ_CAP,
        ST_FINISH
    } state_t;

    // Load cursor position
    typedef struct packed {
        logic [ROW_BITS-1:0]  row;
        logic [NODE_BITS-1:0] col;
    } cursor_t;

    // Controller to datapath
    typedef struct packed {
        logic clr_en;
        logic latch;
        logic exec;
        logic mirror_we;
        logic step_add;
        logic close_rd;
        logic close_add;
        logic read_cap;
        logic emit;
    } ctrl_cmd_t;

    // Datapath to controller
    typedef struct packed {
        cmd_t cmd;
        logic bad_item;
        logic load_full;
        logic asym;
        logic tour_active;
        logic prev_ok;
        logic last;
        logic clear_last;
        logic out_free;
    } dp_status_t;

endpackage

`default_nettype wire

FILE: src/tspmtc_ctrl.sv
`default_nettype none

module tspmtc_ctrl (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_valid,
    output logic                        s_ready,
    input  wire tspmtc_pkg::dp_status_t status,
    output tspmtc_pkg::ctrl_cmd_t       cmd
);

    tspmtc_pkg::state_t state_reg, state_next;

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= tspmtc_pkg::ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            tspmtc_pkg::ST_CLEAR: begin
                if (status.clear_last) state_next = tspmtc_pkg::ST_IDLE;
            end
            tspmtc_pkg::ST_IDLE: begin
                if (s_valid) state_next = tspmtc_pkg::ST_EXEC;
            end
            tspmtc_pkg::ST_EXEC: begin
                case (status.cmd)
                    tspmtc_pkg::CMD_BEGIN_LOAD: begin
                        state_next = tspmtc_pkg::ST_FINISH;
                    end
                    tspmtc_pkg::CMD_WEIGHT: begin
                        if (status.load_full || status.asym) state_next = tspmtc_pkg::ST_FINISH;
                        else state_next = tspmtc_pkg::ST_MIRROR;
                    end
                    tspmtc_pkg::CMD_TOUR: begin
                        if (status.bad_item) state_next = tspmtc_pkg::ST_FINISH;
                        else if (status.tour_active && status.prev_ok)
                            state_next = tspmtc_pkg::ST_STEP_ADD;
                        else if (status.last) state_next = tspmtc_pkg::ST_CLOSE;
                        else state_next = tspmtc_pkg::ST_FINISH;
                    end
                    tspmtc_pkg::CMD_READ: begin
                        if (status.bad_item) state_next = tspmtc_pkg::ST_FINISH;
                        else state_next = tspmtc_pkg::ST_READ_CAP;
                    end
                    default: begin
                        state_next = tspmtc_pkg::ST_FINISH;
                    end
                endcase
            end
            tspmtc_pkg::ST_MIRROR: begin
                state_next = tspmtc_pkg::ST_FINISH;
            end
            tspmtc_pkg::ST_STEP_ADD: begin
                if (status.last) state_next = tspmtc_pkg::ST_CLOSE;
                else state_next = tspmtc_pkg::ST_FINISH;
            end
            tspmtc_pkg::ST_CLOSE: begin
                state_next = tspmtc_pkg::ST_CLOSE_ADD;
            end
            tspmtc_pkg::ST_CLOSE_ADD: begin
                state_next = tspmtc_pkg::ST_FINISH;
            end
            tspmtc_pkg::ST_READ_CAP: begin
                state_next = tspmtc_pkg::ST_FINISH;
            end
            tspmtc_pkg::ST_FINISH: begin
                if (status.out_free) state_next = tspmtc_pkg::ST_IDLE;
            end
            default: begin
                state_next = tspmtc_pkg::ST_CLEAR;
            end
        endcase
    end

    // Command outputs
    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        case (state_reg)
            tspmtc_pkg::ST_CLEAR:     cmd.clr_en = 1'b1;
            tspmtc_pkg::ST_IDLE: begin
                s_ready   = 1'b1;
                cmd.latch = s_valid;
            end
            tspmtc_pkg::ST_EXEC:      cmd.exec      = 1'b1;
            tspmtc_pkg::ST_MIRROR:    cmd.mirror_we = 1'b1;
            tspmtc_pkg::ST_STEP_ADD:  cmd.step_add  = 1'b1;
            tspmtc_pkg::ST_CLOSE:     cmd.close_rd  = 1'b1;
            tspmtc_pkg::ST_CLOSE_ADD: cmd.close_add = 1'b1;
            tspmtc_pkg::ST_READ_CAP:  cmd.read_cap  = 1'b1;
            tspmtc_pkg::ST_FINISH:    cmd.emit      = status.out_free;
            default: begin
                cmd = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: src/tspmtc_dp.sv
`default_nettype none

module tspmtc_dp (
    input  wire logic                                   aclk,
    input  wire logic                                   aresetn,
    // Configuration
    input  wire logic                                   cfg_valid,
    output logic                                        cfg_ready,
    input  wire logic [tspmtc_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  wire logic [tspmtc_pkg::CFG_DATA_BITS-1:0]   cfg_data,
    // Input payload
    input  wire logic [1:0]                             s_command,
    input  wire logic [tspmtc_pkg::WEIGHT_BITS-1:0]     s_weight_value,
    input  wire logic [tspmtc_pkg::NODE_BITS-1:0]       s_vertex,
    input  wire logic [tspmtc_pkg::NODE_BITS-1:0]       s_column_vertex,
    input  wire logic                                   s_tour_end,
    // Result channel
    output logic                                        m_valid,
    input  wire logic                                   m_ready,
    output logic [1:0]                                  m_status,
    output logic [tspmtc_pkg::SUM_BITS-1:0]             m_tour_total,
    output logic                                        m_total_valid,
    output logic [tspmtc_pkg::WEIGHT_BITS-1:0]          m_read_weight,
    output logic                                        m_load_done,
    // Controller link
    input  wire tspmtc_pkg::ctrl_cmd_t                  cmd,
    output tspmtc_pkg::dp_status_t                      status
);

    localparam int NB = tspmtc_pkg::NODE_BITS;
    localparam int RB = tspmtc_pkg::ROW_BITS;
    localparam int AB = tspmtc_pkg::ADDR_BITS;
    localparam int WB = tspmtc_pkg::WEIGHT_BITS;
    localparam int SB = tspmtc_pkg::SUM_BITS;
    localparam logic [RB-1:0] MAX_N = RB'(tspmtc_pkg::MAX_NODES);

    // Weights taken by one row in the current layout
    function automatic logic [RB-1:0] row_len(
        input logic [RB-1:0]     row,
        input logic [RB-1:0]     n,
        input tspmtc_pkg::fmt_t  fmt,
        input logic              asym
    );
        logic [RB-1:0] len;
        len = '0;
        if (asym) begin
            len = n;
        end else begin
            case (fmt)
                tspmtc_pkg::FMT_FULL_MATRIX:    len = n;
                tspmtc_pkg::FMT_LOWER_DIAG_ROW: len = row + RB'(1);
                tspmtc_pkg::FMT_LOWER_ROW:      len = row;
                default:                        len = '0;
            endcase
        end
        return len;
    endfunction

    // Move the cursor past a finished row; with no layout every row is skipped
    function automatic tspmtc_pkg::cursor_t settle(
        input logic [RB-1:0]     row,
        input logic [RB-1:0]     col,
        input logic [RB-1:0]     n,
        input tspmtc_pkg::fmt_t  fmt,
        input logic              asym
    );
        tspmtc_pkg::cursor_t res;
        res.row = row;
        res.col = col[NB-1:0];
        if (row < n) begin
            if (!asym && fmt == tspmtc_pkg::FMT_NONE) begin
                res.row = n;
                res.col = '0;
            end else if (col >= row_len(row, n, fmt, asym)) begin
                res.row = row + RB'(1);
                res.col = '0;
            end
        end
        return res;
    endfunction

    function automatic logic [SB-1:0] sat_add(input logic [SB-1:0] a, input logic [WB-1:0] b);
        logic [SB:0] s;
        s = {1'b0, a} + (SB+1)'(b);
        return s[SB] ? tspmtc_pkg::SUM_MAX : s[SB-1:0];
    endfunction

    // Configuration registers
    logic [tspmtc_pkg::CFG_DATA_BITS-1:0] node_count_reg;
    tspmtc_pkg::fmt_t                     fmt_reg;
    logic                                 asym_reg;

    // Latched item
    tspmtc_pkg::cmd_t cmd_reg;
    logic [WB-1:0]    wval_reg;
    logic [NB-1:0]    v_reg;
    logic [NB-1:0]    c_reg;
    logic             last_reg;

    // Block state
    logic [RB-1:0] row_reg, row_next;
    logic [NB-1:0] col_reg, col_next;
    logic [NB-1:0] mir_row_reg, mir_row_next;
    logic [NB-1:0] mir_col_reg, mir_col_next;
    logic [NB-1:0] first_reg, first_next;
    logic [NB-1:0] prev_reg, prev_next;
    logic [SB-1:0] sum_reg, sum_next;
    logic          active_reg, active_next;
    logic [AB-1:0] clr_cnt_reg;

    // Pending result
    tspmtc_pkg::stat_t res_status_reg, res_status_next;
    logic [SB-1:0]     res_total_reg, res_total_next;
    logic              res_valid_reg, res_valid_next;
    logic [WB-1:0]     res_rd_reg, res_rd_next;

    // Output register
    logic              m_valid_reg;
    tspmtc_pkg::stat_t m_status_reg;
    logic [SB-1:0]     m_total_reg;
    logic              m_total_valid_reg;
    logic [WB-1:0]     m_rd_reg;
    logic              m_load_done_reg;

    // Weight memory
    logic [WB-1:0] weight_mem [2**AB];
    logic [WB-1:0] rdata_reg;
    logic          mem_we;
    logic [AB-1:0] mem_waddr;
    logic [WB-1:0] mem_wdata;
    logic [AB-1:0] mem_raddr;

    logic [RB-1:0]       n;
    tspmtc_pkg::cursor_t cur;
    tspmtc_pkg::cursor_t post;
    logic                v_bad;
    logic                c_bad;
    logic                prev_ok;
    logic                first_ok;
    logic                load_full;
    logic [SB-1:0]       close_sum;

    // Derive node count in use and cursor positions
    always_comb begin
        if (node_count_reg == '0) n = RB'(1);
        else if (node_count_reg > MAX_N) n = MAX_N;
        else n = node_count_reg;
        cur       = settle(row_reg, {1'b0, col_reg}, n, fmt_reg, asym_reg);
        post      = settle(cur.row, {1'b0, cur.col} + RB'(1), n, fmt_reg, asym_reg);
        load_full = cur.row >= n;
        v_bad     = {1'b0, v_reg} >= n;
        c_bad     = {1'b0, c_reg} >= n;
        prev_ok   = {1'b0, prev_reg} < n;
        first_ok  = {1'b0, first_reg} < n;
        close_sum = sat_add(sum_reg, first_ok ? rdata_reg : '0);
    end

    // Status to controller
    always_comb begin
        status.cmd         = cmd_reg;
        status.bad_item    = (cmd_reg == tspmtc_pkg::CMD_READ) ? (v_bad || c_bad) : v_bad;
        status.load_full   = load_full;
        status.asym        = asym_reg;
        status.tour_active = active_reg;
        status.prev_ok     = prev_ok;
        status.last        = last_reg;
        status.clear_last  = clr_cnt_reg == {AB{1'b1}};
        status.out_free    = !m_valid_reg || m_ready;
    end

    // Memory port selection
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = clr_cnt_reg;
        mem_wdata = '0;
        if (cmd.clr_en) begin
            mem_we = 1'b1;
        end else if (cmd.exec && cmd_reg == tspmtc_pkg::CMD_WEIGHT && !load_full) begin
            mem_we    = 1'b1;
            mem_waddr = {cur.row[NB-1:0], cur.col};
            mem_wdata = wval_reg;
        end else if (cmd.mirror_we) begin
            mem_we    = 1'b1;
            mem_waddr = {mir_col_reg, mir_row_reg};
            mem_wdata = wval_reg;
        end
        if (cmd.close_rd) mem_raddr = {v_reg, first_reg};
        else if (cmd_reg == tspmtc_pkg::CMD_READ) mem_raddr = {v_reg, c_reg};
        else mem_raddr = {prev_reg, v_reg};
    end

    // Write and read the weight memory
    always_ff @(posedge aclk) begin
        if (mem_we) weight_mem[mem_waddr] <= mem_wdata;
        rdata_reg <= weight_mem[mem_raddr];
    end

    // Next values of cursor, tour and pending result
    always_comb begin
        row_next        = row_reg;
        col_next        = col_reg;
        mir_row_next    = mir_row_reg;
        mir_col_next    = mir_col_reg;
        first_next      = first_reg;
        prev_next       = prev_reg;
        sum_next        = sum_reg;
        active_next     = active_reg;
        res_status_next = res_status_reg;
        res_total_next  = res_total_reg;
        res_valid_next  = res_valid_reg;
        res_rd_next     = res_rd_reg;
        if (cmd.exec) begin
            res_status_next = tspmtc_pkg::STAT_OK;
            res_total_next  = '0;
            res_valid_next  = 1'b0;
            res_rd_next     = '0;
            case (cmd_reg)
                tspmtc_pkg::CMD_BEGIN_LOAD: begin
                    row_next = '0;
                    col_next = '0;
                end
                tspmtc_pkg::CMD_WEIGHT: begin
                    if (load_full) begin
                        res_status_next = tspmtc_pkg::STAT_LOAD_FULL;
                        row_next        = cur.row;
                        col_next        = cur.col;
                    end else begin
                        mir_row_next = cur.row[NB-1:0];
                        mir_col_next = cur.col;
                        row_next     = post.row;
                        col_next     = post.col;
                    end
                end
                tspmtc_pkg::CMD_TOUR: begin
                    if (v_bad) begin
                        res_status_next = tspmtc_pkg::STAT_BAD_VERTEX;
                    end else begin
                        prev_next = v_reg;
                        if (!active_reg) begin
                            first_next  = v_reg;
                            sum_next    = '0;
                            active_next = 1'b1;
                        end
                    end
                end
                tspmtc_pkg::CMD_READ: begin
                    if (v_bad || c_bad) res_status_next = tspmtc_pkg::STAT_BAD_VERTEX;
                end
                default: begin
                    res_status_next = tspmtc_pkg::STAT_OK;
                end
            endcase
        end
        // Add the edge from the previous vertex
        if (cmd.step_add) sum_next = sat_add(sum_reg, rdata_reg);
        // Add the closing edge and finish the tour
        if (cmd.close_add) begin
            sum_next       = close_sum;
            res_total_next = close_sum;
            res_valid_next = 1'b1;
            active_next    = 1'b0;
        end
        if (cmd.read_cap) res_rd_next = rdata_reg;
    end

    // Control and state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            node_count_reg <= tspmtc_pkg::NODE_COUNT_RESET;
            fmt_reg        <= tspmtc_pkg::FMT_FULL_MATRIX;
            asym_reg       <= 1'b0;
            row_reg        <= '0;
            col_reg        <= '0;
            first_reg      <= '0;
            prev_reg       <= '0;
            sum_reg        <= '0;
            active_reg     <= 1'b0;
            clr_cnt_reg    <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (cfg_valid) begin
                case (cfg_index)
                    tspmtc_pkg::CFG_NODE_COUNT:    node_count_reg <= cfg_data;
                    tspmtc_pkg::CFG_MATRIX_FORMAT: fmt_reg <= tspmtc_pkg::fmt_t'(cfg_data[1:0]);
                    tspmtc_pkg::CFG_ASYMMETRIC:    asym_reg <= cfg_data[0];
                    default: begin
                        asym_reg <= asym_reg;
                    end
                endcase
            end
            row_reg    <= row_next;
            col_reg    <= col_next;
            first_reg  <= first_next;
            prev_reg   <= prev_next;
            sum_reg    <= sum_next;
            active_reg <= active_next;
            if (cmd.clr_en) clr_cnt_reg <= clr_cnt_reg + AB'(1);
            if (cmd.emit) m_valid_reg <= 1'b1;
            else if (m_ready) m_valid_reg <= 1'b0;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (cmd.latch) begin
            cmd_reg  <= tspmtc_pkg::cmd_t'(s_command);
            wval_reg <= s_weight_value;
            v_reg    <= s_vertex;
            c_reg    <= s_column_vertex;
            last_reg <= s_tour_end;
        end
        mir_row_reg    <= mir_row_next;
        mir_col_reg    <= mir_col_next;
        res_status_reg <= res_status_next;
        res_total_reg  <= res_total_next;
        res_valid_reg  <= res_valid_next;
        res_rd_reg     <= res_rd_next;
        if (cmd.emit) begin
            m_status_reg      <= res_status_reg;
            m_total_reg       <= res_total_reg;
            m_total_valid_reg <= res_valid_reg;
            m_rd_reg          <= res_rd_reg;
            m_load_done_reg   <= load_full;
        end
    end

    assign cfg_ready     = 1'b1;
    assign m_valid       = m_valid_reg;
    assign m_status      = m_status_reg;
    assign m_tour_total  = m_total_reg;
    assign m_total_valid = m_total_valid_reg;
    assign m_read_weight = m_rd_reg;
    assign m_load_done   = m_load_done_reg;

endmodule

`default_nettype wire

FILE: src/tsp_matrix_load_and_tour_cost_top.sv
// Order: an accepted item is latched, executed and its result registered at the output;
//   a closing tour vertex does the edge read and add, then the closing-edge read and add.
// A new item is taken only after the previous result is in the output register; the one
//   write port and one read port of the weight memory serialize the mirror write and the
//   two tour reads. Reset: synchronous, active low; afterwards a clearing pass zeroes all
//   16384 matrix entries with s_ready low. Configuration writes are taken throughout.
`default_nettype none

module tsp_matrix_load_and_tour_cost_top (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    input  wire logic                                  cfg_valid,
    output logic                                       cfg_ready,
    input  wire logic [tspmtc_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  wire logic [tspmtc_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    input  wire logic                                  s_valid,
    output logic                                       s_ready,
    input  wire logic [1:0]                            s_command,
    input  wire logic [tspmtc_pkg::WEIGHT_BITS-1:0]    s_weight_value,
    input  wire logic [tspmtc_pkg::NODE_BITS-1:0]      s_vertex,
    input  wire logic [tspmtc_pkg::NODE_BITS-1:0]      s_column_vertex,
    input  wire logic                                  s_tour_end,
    output logic                                       m_valid,
    input  wire logic                                  m_ready,
    output logic [1:0]                                 m_status,
    output logic [tspmtc_pkg::SUM_BITS-1:0]            m_tour_total,
    output logic                                       m_total_valid,
    output logic [tspmtc_pkg::WEIGHT_BITS-1:0]         m_read_weight,
    output logic                                       m_load_done
);

    tspmtc_pkg::ctrl_cmd_t  cmd;
    tspmtc_pkg::dp_status_t status;

    // Sequencer
    tspmtc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // Matrix, cursor and tour datapath
    tspmtc_dp u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .s_command       (s_command),
        .s_weight_value  (s_weight_value),
        .s_vertex        (s_vertex),
        .s_column_vertex (s_column_vertex),
        .s_tour_end      (s_tour_end),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_status        (m_status),
        .m_tour_total    (m_tour_total),
        .m_total_valid   (m_total_valid),
        .m_read_weight   (m_read_weight),
        .m_load_done     (m_load_done),
        .cmd             (cmd),
        .status          (status)
    );

endmodule

`default_nettype wire

FILE: tb/sv/tb_tsp_matrix_load_and_tour_cost_top.sv
`default_nettype none

module tb_tsp_matrix_load_and_tour_cost_top;
    timeunit 1ns;
    timeprecision 1ps;

    import tspmtc_pkg::*;

    localparam int ITEM_TARGET   = 1100;
    localparam int SETTLE_CYCLES = 12;
    localparam int CYCLE_LIMIT   = MAX_NODES * MAX_NODES + 400000;
    localparam int PRINT_LIMIT   = 100;

    typedef struct packed {
        cmd_t                   cmd;
        logic [WEIGHT_BITS-1:0] weight;
        logic [NODE_BITS-1:0]   vertex;
        logic [NODE_BITS-1:0]   column;
        logic                   tour_end;
    } tour_item_t;

    typedef struct packed {
        logic [1:0]             status;
        logic [SUM_BITS-1:0]    total;
        logic                   total_valid;
        logic [WEIGHT_BITS-1:0] read_weight;
        logic                   load_done;
    } tour_result_t;

    // Mirror of the weight matrix, load cursor and tour accumulator
    class tour_cost_scoreboard;
        logic [WEIGHT_BITS-1:0] weights [MAX_NODES*MAX_NODES];
        int unsigned            load_row;
        int unsigned            load_col;
        int unsigned            first_vertex;
        int unsigned            prev_vertex;
        logic [SUM_BITS-1:0]    path_sum;
        bit                     tour_open;
        logic [CFG_DATA_BITS-1:0] node_count;
        fmt_t                   layout;
        bit                     asym;
        tour_result_t           expected_q[$];
        string                  faults[$];

        function new();
            foreach (weights[i]) weights[i] = '0;
            load_row     = 0;
            load_col     = 0;
            first_vertex = 0;
            prev_vertex  = 0;
            path_sum     = '0;
            tour_open    = 1'b0;
            node_count   = NODE_COUNT_RESET;
            layout       = FMT_FULL_MATRIX;
            asym         = 1'b0;
        endfunction

        // Clamp node_count into 1..MAX_NODES
        function int unsigned live_nodes();
            if (node_count == 0) return 1;
            if (node_count > MAX_NODES) return MAX_NODES;
            return node_count;
        endfunction

        function int unsigned row_span(int unsigned row, int unsigned n);
            if (asym || layout == FMT_FULL_MATRIX) return n;
            if (layout == FMT_LOWER_DIAG_ROW) return row + 1;
            if (layout == FMT_LOWER_ROW) return row;
            return 0;
        endfunction

        // Advance the cursor past rows that are full or take no weights
        function void skip_rows(inout int unsigned row, inout int unsigned col,
                                input int unsigned n);
            while (row < n && col >= row_span(row, n)) begin
                row++;
                col = 0;
            end
        endfunction

        function logic [SUM_BITS-1:0] sat_add(logic [SUM_BITS-1:0] a,
                                              logic [WEIGHT_BITS-1:0] b);
            logic [SUM_BITS:0] s;
            s = {1'b0, a} + {{(SUM_BITS+1-WEIGHT_BITS){1'b0}}, b};
            return s[SUM_BITS] ? SUM_MAX : s[SUM_BITS-1:0];
        endfunction

        function void note_config(logic [CFG_INDEX_BITS-1:0] index,
                                  logic [CFG_DATA_BITS-1:0] data);
            case (index)
                CFG_NODE_COUNT:    node_count = data;
                CFG_MATRIX_FORMAT: layout = fmt_t'(data[1:0]);
                CFG_ASYMMETRIC:    asym = data[0];
                default: ;
            endcase
        endfunction

        // Apply one accepted transaction and queue the result it must produce
        function void note_item(tour_item_t it);
            tour_result_t r;
            int unsigned  n;
            int unsigned  row;
            int unsigned  col;
            n = live_nodes();
            r = '0;
            case (it.cmd)
                CMD_BEGIN_LOAD: begin
                    load_row = 0;
                    load_col = 0;
                end
                CMD_WEIGHT: begin
                    skip_rows(load_row, load_col, n);
                    if (load_row >= n) begin
                        r.status = STAT_LOAD_FULL;
                    end else begin
                        weights[load_row*MAX_NODES + load_col] = it.weight;
                        if (!asym) weights[load_col*MAX_NODES + load_row] = it.weight;
                        load_col++;
                        skip_rows(load_row, load_col, n);
                    end
                end
                CMD_TOUR: begin
                    if (it.vertex >= n) begin
                        r.status = STAT_BAD_VERTEX;
                    end else begin
                        if (!tour_open) begin
                            first_vertex = it.vertex;
                            path_sum     = '0;
                            tour_open    = 1'b1;
                        end else if (prev_vertex < n) begin
                            path_sum = sat_add(path_sum,
                                               weights[prev_vertex*MAX_NODES + it.vertex]);
                        end
                        prev_vertex = it.vertex;
                        // Close the loop back to the first vertex
                        if (it.tour_end) begin
                            if (first_vertex < n)
                                path_sum = sat_add(path_sum,
                                                   weights[it.vertex*MAX_NODES + first_vertex]);
                            r.total       = path_sum;
                            r.total_valid = 1'b1;
                            tour_open     = 1'b0;
                        end
                    end
                end
                default: begin
                    if (it.vertex >= n || it.column >= n)
                        r.status = STAT_BAD_VERTEX;
                    else
                        r.read_weight = weights[it.vertex*MAX_NODES + it.column];
                end
            endcase
            row = load_row;
            col = load_col;
            skip_rows(row, col, n);
            r.load_done = (row >= n);
            expected_q.push_back(r);
        endfunction

        // Compare a result with the oldest expectation, one fault per field
        function void check_result(tour_result_t got);
            tour_result_t want;
            faults.delete();
            if (expected_q.size() == 0) begin
                faults.push_back($sformatf("result with no transaction pending: status %0d",
                                           got.status));
                return;
            end
            want = expected_q.pop_front();
            if (got.status !== want.status)
                faults.push_back($sformatf("status got %0d want %0d", got.status, want.status));
            if (got.total !== want.total)
                faults.push_back($sformatf("tour_total got %0d want %0d",
                                           got.total, want.total));
            if (got.total_valid !== want.total_valid)
                faults.push_back($sformatf("total_valid got %0b want %0b",
                                           got.total_valid, want.total_valid));
            if (got.read_weight !== want.read_weight)
                faults.push_back($sformatf("read_weight got %06h want %06h",
                                           got.read_weight, want.read_weight));
            if (got.load_done !== want.load_done)
                faults.push_back($sformatf("load_done got %0b want %0b",
                                           got.load_done, want.load_done));
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic                      aclk            = 1'b0;
    logic                      aresetn         = 1'b0;
    logic                      cfg_valid       = 1'b0;
    logic                      cfg_ready;
    logic [CFG_INDEX_BITS-1:0] cfg_index       = '0;
    logic [CFG_DATA_BITS-1:0]  cfg_data        = '0;
    logic                      s_valid         = 1'b0;
    logic                      s_ready;
    logic [1:0]                s_command       = '0;
    logic [WEIGHT_BITS-1:0]    s_weight_value  = '0;
    logic [NODE_BITS-1:0]      s_vertex        = '0;
    logic [NODE_BITS-1:0]      s_column_vertex = '0;
    logic                      s_tour_end      = 1'b0;
    logic                      m_valid;
    logic                      m_ready         = 1'b0;
    logic [1:0]                m_status;
    logic [SUM_BITS-1:0]       m_tour_total;
    logic                      m_total_valid;
    logic [WEIGHT_BITS-1:0]    m_read_weight;
    logic                      m_load_done;

    tour_cost_scoreboard sb = new();
    int mismatch_count = 0;
    int items_sent     = 0;
    int cycle_count    = 0;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;

    tsp_matrix_load_and_tour_cost_top dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_command       (s_command),
        .s_weight_value  (s_weight_value),
        .s_vertex        (s_vertex),
        .s_column_vertex (s_column_vertex),
        .s_tour_end      (s_tour_end),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_status        (m_status),
        .m_tour_total    (m_tour_total),
        .m_total_valid   (m_total_valid),
        .m_read_weight   (m_read_weight),
        .m_load_done     (m_load_done)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Stop a hung run
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("[tsp_matrix_load_and_tour_cost_top] ERROR");
            $finish;
        end
    end

    task automatic report(string msg);
        mismatch_count++;
        if (mismatch_count <= PRINT_LIMIT) $display("%0t mismatch: %s", $time, msg);
    endtask

    // Check each result transaction, then pick the next ready level
    always @(posedge aclk) begin
        tour_result_t got;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                got = {m_status, m_tour_total, m_total_valid, m_read_weight, m_load_done};
                sb.check_result(got);
                foreach (sb.faults[i]) report(sb.faults[i]);
            end
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    function automatic logic [NODE_BITS-1:0] any_node();
        return NODE_BITS'($urandom_range(MAX_NODES - 1));
    endfunction

    // Mix of zero, full scale, small and random weights
    function automatic logic [WEIGHT_BITS-1:0] pick_weight();
        case ($urandom_range(7))
            0:       return '0;
            1:       return '1;
            2, 3, 4: return WEIGHT_BITS'($urandom_range(255));
            default: return WEIGHT_BITS'($urandom);
        endcase
    endfunction

    // Drive one input transaction and hold it until accepted
    task automatic send_item(cmd_t cmd, logic [WEIGHT_BITS-1:0] w, logic [NODE_BITS-1:0] v,
                             logic [NODE_BITS-1:0] c, logic last);
        tour_item_t it;
        it = '{cmd, w, v, c, last};
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid         <= 1'b1;
        s_command       <= cmd;
        s_weight_value  <= w;
        s_vertex        <= v;
        s_column_vertex <= c;
        s_tour_end      <= last;
        do @(posedge aclk); while (!s_ready);
        sb.note_item(it);
        items_sent++;
    endtask

    // Drop valid and wait for every outstanding result
    task automatic wait_idle();
        s_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Write all three registers back to back
    task automatic set_config(logic [CFG_DATA_BITS-1:0] nc, fmt_t fmt, logic asym_bit);
        logic [CFG_INDEX_BITS-1:0] regs [3];
        logic [CFG_DATA_BITS-1:0]  vals [3];
        regs = '{CFG_NODE_COUNT, CFG_MATRIX_FORMAT, CFG_ASYMMETRIC};
        vals = '{nc, CFG_DATA_BITS'(fmt), CFG_DATA_BITS'(asym_bit)};
        for (int i = 0; i < 3; i++) begin
            cfg_valid <= 1'b1;
            cfg_index <= regs[i];
            cfg_data  <= vals[i];
            do @(posedge aclk); while (!cfg_ready);
            sb.note_config(regs[i], vals[i]);
        end
        cfg_valid <= 1'b0;
    endtask

    initial begin
        int                       phase;
        int unsigned              n_eff;
        int unsigned              load_len;
        int unsigned              steps;
        logic [CFG_DATA_BITS-1:0] nc;
        fmt_t                     fmt;
        logic                     asym_bit;
        logic [NODE_BITS-1:0]     v;

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: cleared matrix at reset settings, far corner, self loop
        send_item(CMD_READ, '0, 7'd127, 7'd127, 1'b0);
        send_item(CMD_TOUR, '0, 7'd127, 7'd0, 1'b1);
        send_item(CMD_WEIGHT, '1, 7'd0, 7'd0, 1'b0);
        send_item(CMD_READ, '0, 7'd0, 7'd0, 1'b0);
        wait_idle();

        // Directed: lower-with-diagonal load of three nodes, then overflow
        set_config(8'd3, FMT_LOWER_DIAG_ROW, 1'b0);
        send_item(CMD_BEGIN_LOAD, '1, '1, '1, 1'b1);
        for (int i = 0; i < 6; i++)
            send_item(CMD_WEIGHT, (i == 0) ? '0 : (i == 5) ? '1 : pick_weight(),
                      any_node(), any_node(), 1'b0);
        send_item(CMD_WEIGHT, 24'h5a5a5a, '0, '0, 1'b0);
        send_item(CMD_READ, '0, 7'd2, 7'd0, 1'b0);
        send_item(CMD_READ, '0, 7'd0, 7'd2, 1'b0);
        send_item(CMD_READ, '0, 7'd3, 7'd0, 1'b0);
        send_item(CMD_READ, '0, 7'd0, 7'd127, 1'b0);
        // Tour, bad vertex with end mark, single-vertex tour
        send_item(CMD_TOUR, '0, 7'd0, '0, 1'b0);
        send_item(CMD_TOUR, '0, 7'd1, '0, 1'b0);
        send_item(CMD_TOUR, '0, 7'd2, '0, 1'b1);
        send_item(CMD_TOUR, '0, 7'd5, '0, 1'b1);
        send_item(CMD_TOUR, '0, 7'd1, '0, 1'b1);
        // Rewind the load while a tour is open
        send_item(CMD_TOUR, '0, 7'd0, '0, 1'b0);
        send_item(CMD_BEGIN_LOAD, '0, '0, '0, 1'b0);
        send_item(CMD_TOUR, '0, 7'd2, '0, 1'b1);

        // Random phases, each with its own settings and idle mix
        phase = 0;
        while (items_sent < ITEM_TARGET) begin
            wait_idle();
            case (phase % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 83; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 83; end
                default: begin send_idle_pct = 11; recv_stall_pct = 11; end
            endcase
            case (phase)
                0: begin nc = 8'd255; fmt = FMT_LOWER_ROW;      asym_bit = 1'b0; end
                1: begin nc = 8'd0;   fmt = FMT_FULL_MATRIX;    asym_bit = 1'b1; end
                2: begin nc = 8'd4;   fmt = FMT_NONE;           asym_bit = 1'b0; end
                3: begin nc = 8'd2;   fmt = FMT_FULL_MATRIX;    asym_bit = 1'b0; end
                4: begin nc = 8'd128; fmt = FMT_FULL_MATRIX;    asym_bit = 1'b1; end
                5: begin nc = 8'd1;   fmt = FMT_LOWER_ROW;      asym_bit = 1'b0; end
                6: begin nc = 8'd7;   fmt = FMT_LOWER_DIAG_ROW; asym_bit = 1'b1; end
                default: begin
                    nc = ($urandom_range(9) == 0) ? CFG_DATA_BITS'($urandom_range(255))
                                                  : CFG_DATA_BITS'($urandom_range(9, 1));
                    fmt      = fmt_t'($urandom_range(3));
                    asym_bit = 1'($urandom_range(1));
                end
            endcase
            set_config(nc, fmt, asym_bit);
            n_eff = (nc == 0) ? 1 : (nc > MAX_NODES) ? MAX_NODES : nc;

            // Size the load to fill the matrix, or part of it when large
            if (asym_bit || fmt == FMT_FULL_MATRIX) load_len = n_eff * n_eff;
            else if (fmt == FMT_LOWER_DIAG_ROW)     load_len = n_eff * (n_eff + 1) / 2;
            else if (fmt == FMT_LOWER_ROW)          load_len = n_eff * (n_eff - 1) / 2;
            else                                    load_len = 0;
            if (load_len > 100) load_len = $urandom_range(40, 10);
            else load_len += $urandom_range(2);

            send_item(CMD_BEGIN_LOAD, pick_weight(), any_node(), any_node(),
                      1'($urandom_range(1)));
            for (int unsigned i = 0; i < load_len; i++)
                send_item(CMD_WEIGHT, (phase == 3) ? '1 : pick_weight(), any_node(),
                          any_node(), 1'($urandom_range(1)));

            if (phase == 3) begin
                // Long tour over full-scale weights to reach saturation
                for (int s = 0; s < 140; s++)
                    send_item(CMD_TOUR, pick_weight(), NODE_BITS'(s % 2), any_node(),
                              s == 139);
            end else begin
                // Tours with an occasional bad vertex or missing end mark
                for (int t = $urandom_range(5, 2); t > 0; t--) begin
                    steps = $urandom_range((n_eff > 10) ? 12 : n_eff + 2, 1);
                    for (int unsigned s = 0; s < steps; s++) begin
                        v = ($urandom_range(15) == 0) ? any_node()
                                                      : NODE_BITS'($urandom_range(n_eff - 1));
                        send_item(CMD_TOUR, pick_weight(), v, any_node(),
                                  (s == steps - 1) && ($urandom_range(7) != 0));
                    end
                end
            end

            // Hold off the sender until the pipe is empty
            if (phase % 5 == 2) wait_idle();

            for (int i = 0; i < 6; i++) begin
                if ($urandom_range(7) == 0)
                    send_item(CMD_READ, pick_weight(), any_node(), any_node(), 1'b0);
                else
                    send_item(CMD_READ, pick_weight(), NODE_BITS'($urandom_range(n_eff - 1)),
                              NODE_BITS'($urandom_range(n_eff - 1)), 1'($urandom_range(1)));
            end

            // Noise: fully random transactions
            for (int i = 0; i < 3; i++)
                send_item(cmd_t'($urandom_range(3)), WEIGHT_BITS'($urandom), any_node(),
                          any_node(), 1'($urandom_range(1)));
            phase++;
        end

        wait_idle();
        if (mismatch_count == 0) begin
            $display("[tsp_matrix_load_and_tour_cost_top] OK");
        end else begin
            $display("[tsp_matrix_load_and_tour_cost_top] ERROR");
        end
        $finish;
    end

endmodule

`default_nettype wire
